[rtl/suk_set_pkg.sv]
// shared constants, types and control codes for the sorted key set
package suk_set_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 32;
    localparam int POS_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_upd_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
        logic             lt;
    } cell_view_t;

endpackage

[rtl/sorted_unique_key_set_top.sv]
// top level: sequencer, cell chain and result register of the sorted key set
//
//  channel  | dir | ports                            | contents
//  ---------+-----+----------------------------------+----------------------------------
//  command  | in  | s_tvalid s_tready s_tdata s_tuser | key in tdata, operation in tuser
//  result   | out | m_tvalid m_tready m_tdata         | found, position, count, reject
//
//  an item is handled in order: the accept edge latches every cell's compare against the
//  key, then the apply state shifts the chain and loads the result register
//  the result register holds one word; a new word is accepted while it waits
//  if the result register is still full the update waits in the apply state
//  reset (aresetn low at a clock edge) empties the set and the result register
module sorted_unique_key_set_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] found, [7:1] position, [14:8] entry_count,
                                   // [15] full_reject
);

    localparam int CAP   = suk_set_pkg::CAPACITY;
    localparam int POS_W = suk_set_pkg::POS_W;
    localparam int CW    = suk_set_pkg::OUT_CNT_W;

    suk_set_pkg::state_t state_reg, state_next;

    logic [suk_set_pkg::KEY_W-1:0] key_reg;
    logic [1:0]                    op_reg;
    logic [POS_W-1:0]              count_reg, count_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [15:0]                   m_tdata_reg, m_tdata_next;

    suk_set_pkg::cell_view_t view [CAP];
    suk_set_pkg::cell_view_t left_view [CAP];
    suk_set_pkg::cell_view_t right_view [CAP];
    logic [CAP-1:0]          eq_vec;
    logic [CAP-1:0]          lt_vec;
    logic [CAP-1:0]          valid_vec;
    suk_set_pkg::cell_upd_t  upd;

    logic             accept;
    logic             out_free;
    logic             found;
    logic             full;
    logic             do_ins;
    logic             do_rem;
    logic             reject;
    logic [POS_W-1:0] pos;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            if (g == 0) begin : g_first
                // slot 0 always sees an open boundary on its left
                assign left_view[g] = '{key: '0, valid: 1'b0, lt: 1'b1};
            end else begin : g_mid
                assign left_view[g] = view[g-1];
            end
            if (g == CAP - 1) begin : g_last
                assign right_view[g] = '{key: '0, valid: 1'b0, lt: 1'b0};
            end else begin : g_body
                assign right_view[g] = view[g+1];
            end

            suk_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmp_en     (accept),
                .cmp_key    (s_tdata),
                .new_key    (key_reg),
                .upd        (upd),
                .left_view  (left_view[g]),
                .right_view (right_view[g]),
                .view       (view[g]),
                .eq         (eq_vec[g])
            );

            assign lt_vec[g]    = view[g].lt;
            assign valid_vec[g] = view[g].valid;
        end
    endgenerate

    // lt flags form a thermometer code, so the position is its top edge
    always_comb begin
        pos = '0;
        for (int i = 0; i < CAP; i++) begin
            if (lt_vec[i] && (i == CAP - 1 || !lt_vec[(i + 1) % CAP])) begin
                pos = pos | POS_W'(i + 1);
            end
        end
    end

    assign found  = |eq_vec;
    assign full   = (count_reg == POS_W'(CAP));
    assign do_ins = (op_reg == suk_set_pkg::OP_INSERT) && !found && !full;
    assign do_rem = (op_reg == suk_set_pkg::OP_REMOVE) && found;
    assign reject = (op_reg == suk_set_pkg::OP_INSERT) && !found && full;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        upd           = '{ins: 1'b0, rem: 1'b0};
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            suk_set_pkg::ST_IDLE: begin
                // no word is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = suk_set_pkg::ST_APPLY;
                end
            end
            suk_set_pkg::ST_APPLY: begin
                if (out_free) begin
                    upd.ins = do_ins;
                    upd.rem = do_rem;
                    if (do_ins) begin
                        count_next = count_reg + POS_W'(1);
                    end else if (do_rem) begin
                        count_next = count_reg - POS_W'(1);
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {reject, CW'(count_next), CW'(pos), found};
                    state_next    = suk_set_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = suk_set_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg <= s_tdata;
            op_reg  <= s_tuser;
        end
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= suk_set_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // the occupied slots always match the count
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with key count");

    // count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POS_W'(CAP))
        else $error("key count above capacity");

    // a rejected insert never reports a present key and leaves the count at capacity
    a_reject_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[15]) |-> (!m_tdata_reg[0] &&
        m_tdata_reg[14:8] == CW'(CAP)))
        else $error("full reject with inconsistent result");

    // a compare is never overwritten while its update is pending
    a_no_accept_in_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == suk_set_pkg::ST_APPLY) |-> !s_tready)
        else $error("word accepted during apply");
`endif

endmodule

[rtl/suk_cell.sv]
// one slot of the sorted key chain: holds a key, compares it, shifts with neighbors
module suk_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmp_en,
    input  logic [suk_set_pkg::KEY_W-1:0]    cmp_key,
    input  logic [suk_set_pkg::KEY_W-1:0]    new_key,
    input  suk_set_pkg::cell_upd_t           upd,
    input  suk_set_pkg::cell_view_t          left_view,
    input  suk_set_pkg::cell_view_t          right_view,
    output suk_set_pkg::cell_view_t          view,
    output logic                             eq
);

    logic [suk_set_pkg::KEY_W-1:0] key_reg, key_next;
    logic                          valid_reg, valid_next;
    logic                          lt_reg;
    logic                          eq_reg;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (upd.ins && !lt_reg) begin
            if (left_view.lt) begin
                // boundary slot takes the new key
                key_next   = new_key;
                valid_next = 1'b1;
            end else begin
                key_next   = left_view.key;
                valid_next = left_view.valid;
            end
        end else if (upd.rem && !lt_reg) begin
            key_next   = right_view.key;
            valid_next = right_view.valid;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmp_en) begin
                lt_reg <= valid_reg && ($signed(key_reg) < $signed(cmp_key));
                eq_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    assign view.key   = key_reg;
    assign view.valid = valid_reg;
    assign view.lt    = lt_reg;
    assign eq         = eq_reg;

endmodule
